@@ rtl/fss_pkg.sv @@
// Shared types, constants and helpers for the fuzzy subsequence scorer.
`default_nettype none

package fss_pkg;

    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_SLASH = 8'h2F;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_CASE_BIT = 8'h20;

    localparam logic [4:0] SCORE_MATCH = 5'd10;
    localparam logic [4:0] SCORE_ADJACENT = 5'd8;
    localparam logic [4:0] SCORE_WORD_START = 5'd6;
    localparam logic [4:0] SCORE_COMMAND = 5'd4;

    localparam int LEN_PENALTY_SHIFT = 4;
    localparam int INDEX_PENALTY_SHIFT = 6;

    localparam int SCORE_W = 12;
    localparam int RUN_W = 10;
    localparam int INDEX_W = 16;
    localparam int QLEN_W = 5;
    localparam int QWORD_W = 64;

    typedef enum logic [1:0] {
        CFG_QUERY_LOW  = 2'd0,
        CFG_QUERY_HIGH = 2'd1,
        CFG_QUERY_LEN  = 2'd2
    } fss_cfg_idx_t;

    typedef struct packed {
        logic [QWORD_W-1:0] chars_low;
        logic [QWORD_W-1:0] chars_high;
        logic [QLEN_W-1:0]  length;
    } fss_cfg_t;

    typedef struct packed {
        logic [7:0]         char_byte;
        logic               in_command;
        logic [INDEX_W-1:0] entry_index;
        logic               last_char;
    } fss_word_t;

    typedef struct packed {
        logic               valid;
        logic [SCORE_W-1:0] score;
        logic [INDEX_W-1:0] index;
    } fss_result_t;

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z)
        begin
            r = c | ASCII_CASE_BIT;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/fss_match_core.sv @@
// Per-entry greedy match state and scoring for one text byte per step.
`default_nettype none

module fss_match_core
    import fss_pkg::*;
#(
    parameter int MAX_QUERY_CHARS = 16,
    parameter int MAX_TEXT_LEN = 4096
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire fss_word_t   word,
    input  wire fss_cfg_t    cfg,
    output fss_result_t      result
);

    localparam int QW = $clog2(MAX_QUERY_CHARS + 1);
    localparam int POSW = $clog2(MAX_TEXT_LEN);

    logic [QW-1:0]    ptr_reg, ptr_next;
    logic [POSW-1:0]  pos_reg, pos_next;
    logic [7:0]       prev_byte_reg, prev_byte_next;
    logic             prev_matched_reg, prev_matched_next;
    logic [RUN_W-1:0] run_reg, run_next;

    logic [2*QWORD_W-1:0]       qall;
    logic [QW-1:0]              n_used;
    logic [7:0]                 c;
    logic [MAX_QUERY_CHARS-1:0] nonspace, cand, first, eq, sfx;
    logic                       hit, found, pending;
    logic [QW-1:0]              first_idx, ptr_upd;
    logic [4:0]                 add;
    logic [RUN_W-1:0]           run_upd;
    logic [POSW-1:0]            pos_upd;
    logic [17:0]                score_full;

    assign qall = {cfg.chars_high, cfg.chars_low};
    assign c = lower_ascii(word.char_byte);
    assign n_used = (cfg.length > QLEN_W'(MAX_QUERY_CHARS)) ? QW'(MAX_QUERY_CHARS)
                                                            : QW'(cfg.length);

    always_comb
    begin
        logic seen;
        logic tail;
        seen = 1'b0;
        tail = 1'b0;
        first_idx = '0;
        for (int i = 0; i < MAX_QUERY_CHARS; i++)
        begin
            nonspace[i] = (QW'(i) < n_used) && (lower_ascii(qall[8*i +: 8]) != ASCII_SPACE);
            eq[i] = (lower_ascii(qall[8*i +: 8]) == c);
            cand[i] = nonspace[i] && (QW'(i) >= ptr_reg);
            first[i] = cand[i] && !seen;
            seen = seen | cand[i];
            if (first[i])
            begin
                first_idx = QW'(i);
            end
        end
        for (int i = MAX_QUERY_CHARS - 1; i >= 0; i--)
        begin
            sfx[i] = tail;
            tail = tail | nonspace[i];
        end
    end

    assign found = |first;
    assign hit = |(first & eq);
    assign pending = |(first & (~eq | sfx));

    always_comb
    begin
        if (hit)
        begin
            ptr_upd = first_idx + QW'(1);
        end
        else if (found)
        begin
            ptr_upd = first_idx;
        end
        else if (ptr_reg < n_used)
        begin
            ptr_upd = n_used;
        end
        else
        begin
            ptr_upd = ptr_reg;
        end
    end

    always_comb
    begin
        add = SCORE_MATCH;
        if (prev_matched_reg)
        begin
            add = add + SCORE_ADJACENT;
        end
        if (pos_reg == '0 || prev_byte_reg == ASCII_SPACE || prev_byte_reg == ASCII_SLASH)
        begin
            add = add + SCORE_WORD_START;
        end
        if (word.in_command)
        begin
            add = add + SCORE_COMMAND;
        end
    end

    assign run_upd = hit ? (run_reg + RUN_W'(add)) : run_reg;
    assign pos_upd = (pos_reg == POSW'(MAX_TEXT_LEN - 1)) ? pos_reg : (pos_reg + POSW'(1));

    // Empty query scores only the recency penalty.
    always_comb
    begin
        if (n_used == '0)
        begin
            score_full = 18'd0 - 18'(word.entry_index >> INDEX_PENALTY_SHIFT);
        end
        else
        begin
            score_full = 18'(run_upd) - 18'(pos_upd >> LEN_PENALTY_SHIFT)
                         - 18'(word.entry_index >> INDEX_PENALTY_SHIFT);
        end
    end

    always_comb
    begin
        result.valid = step && word.last_char && !pending;
        result.score = score_full[SCORE_W-1:0];
        result.index = word.entry_index;
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        pos_next = pos_reg;
        prev_byte_next = prev_byte_reg;
        prev_matched_next = prev_matched_reg;
        run_next = run_reg;
        if (step)
        begin
            if (word.last_char)
            begin
                ptr_next = '0;
                pos_next = '0;
                prev_byte_next = '0;
                prev_matched_next = 1'b0;
                run_next = '0;
            end
            else
            begin
                ptr_next = ptr_upd;
                pos_next = pos_upd;
                prev_byte_next = c;
                prev_matched_next = hit;
                run_next = run_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
            pos_reg <= '0;
            prev_byte_reg <= '0;
            prev_matched_reg <= 1'b0;
            run_reg <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
            pos_reg <= pos_next;
            prev_byte_reg <= prev_byte_next;
            prev_matched_reg <= prev_matched_next;
            run_reg <= run_next;
        end
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        step && word.last_char |=> ptr_reg == '0 && pos_reg == '0 && run_reg == '0)
        else $error("entry state not cleared after last byte");

    a_ptr_moves_on_step_only: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(ptr_reg) && $stable(pos_reg) && $stable(run_reg))
        else $error("entry state changed without a step");

    a_adjacent_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        prev_matched_reg |-> pos_reg != '0)
        else $error("adjacent flag set at entry start");

endmodule

`default_nettype wire

@@ rtl/fuzzy_subsequence_scorer_top.sv @@
// Top level of the fuzzy subsequence scorer: config registers and word pipeline.
//
// Usage: program the query with the config write port (cfg_we, cfg_index,
// cfg_data) while no entry is in flight: index 0 and 1 hold query bytes 0..15,
// index 2 the number of bytes in use. Then stream each history entry one text
// byte per word on the input channel (valid/ready), with last_char set on the
// entry's final byte. A matching entry gives one result word (match_score,
// result_index) on the output channel; an entry that does not match gives none.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// greedy pointer update in the match core. A result word is scored out of the
// input register straight into the result register, which drives out_valid.
// When the receiver stalls, the result register holds and the input register
// holds one more byte; in_ready drops only while both are full.
// Reset clears the query, the per-entry state and the valid flags of both pipeline registers.
`default_nettype none

module fuzzy_subsequence_scorer_top
    import fss_pkg::*;
#(
    parameter int MAX_QUERY_CHARS = 16,
    parameter int MAX_TEXT_LEN = 4096
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [QWORD_W-1:0]         cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [7:0]                 char_byte,
    input  wire logic                       in_command,
    input  wire logic [INDEX_W-1:0]         entry_index,
    input  wire logic                       last_char,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [SCORE_W-1:0]       match_score,
    output logic [INDEX_W-1:0]              result_index
);

    fss_cfg_t    cfg_reg, cfg_next;
    fss_word_t   word_reg, word_next;
    logic        in_valid_reg, in_valid_next;
    logic        out_valid_reg, out_valid_next;
    logic signed [SCORE_W-1:0] out_score_reg, out_score_next;
    logic [INDEX_W-1:0]        out_index_reg, out_index_next;
    logic        advance, step, in_take;
    fss_result_t result;

    assign advance = !out_valid_reg || out_ready;
    assign step = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;
    assign in_take = in_valid && in_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_QUERY_LOW:  cfg_next.chars_low = cfg_data;
                CFG_QUERY_HIGH: cfg_next.chars_high = cfg_data;
                CFG_QUERY_LEN:  cfg_next.length = cfg_data[QLEN_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        word_next = word_reg;
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            word_next.char_byte = char_byte;
            word_next.in_command = in_command;
            word_next.entry_index = entry_index;
            word_next.last_char = last_char;
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_score_next = out_score_reg;
        out_index_next = out_index_reg;
        if (advance)
        begin
            out_valid_next = result.valid;
            if (result.valid)
            begin
                out_score_next = $signed(result.score);
                out_index_next = result.index;
            end
        end
    end

    fss_match_core #(
        .MAX_QUERY_CHARS(MAX_QUERY_CHARS),
        .MAX_TEXT_LEN(MAX_TEXT_LEN)
    ) u_core (
        .clk(clk),
        .rst_n(rst_n),
        .step(step),
        .word(word_reg),
        .cfg(cfg_reg),
        .result(result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        out_score_reg <= out_score_next;
        out_index_reg <= out_index_next;
    end

    assign out_valid = out_valid_reg;
    assign match_score = out_score_reg;
    assign result_index = out_index_reg;

    a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled with room in the pipeline");

    a_result_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !(in_valid_reg && word_reg.last_char) |=> !out_valid_reg)
        else $error("result word without a last byte");

    a_word_held_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(word_reg))
        else $error("stalled input word lost or changed");

endmodule

`default_nettype wire
